// File: rtl/sqbn_pkg.sv
package sqbn_pkg;

    // register map
    localparam int  APB_ADDR_W   = 3;
    localparam logic REG_TOLERANCE = 1'b0;
    localparam logic [15:0] TOLERANCE_RESET = 16'd66;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TEST,
        ST_BIS_MUL,
        ST_BIS_UPD,
        ST_NEW_DIV,
        ST_FIN
    } sqbn_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic mid_load;
        logic mul;
        logic bis_upd;
        logic new_shift;
        logic div_start;
        logic new_upd;
        logic out_load;
    } sqbn_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic stop;
        logic newton;
        logic q_zero;
        logic div_done;
        logic out_free;
    } sqbn_status_t;

endpackage

// File: rtl/sqbn_div.sv
module sqbn_div #(
    parameter int DW = 48
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic [DW-1:0] quot,
    output logic          done
);

    localparam int CW = $clog2(DW);
    localparam logic [CW-1:0] LAST = CW'(DW - 1);

    logic [DW-1:0] quot_reg, quot_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] dvs_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [DW:0] trial;
    logic [DW:0] trial_sub;
    logic        ge;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        trial     = {rem_reg, quot_reg[DW-1]};
        trial_sub = trial - {1'b0, dvs_reg};
        ge        = (trial >= {1'b0, dvs_reg});
        rem_next  = ge ? trial_sub[DW-1:0] : trial[DW-1:0];
        quot_next = {quot_reg[DW-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
        end
    end

    assign quot = quot_reg;
    assign done = done_reg;

endmodule

// File: rtl/sqbn_dp.sv
module sqbn_dp #(
    parameter int FRAC_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sqbn_pkg::sqbn_cmd_t   cmd,
    output sqbn_pkg::sqbn_status_t status,
    input  logic [15:0]           tolerance,
    input  logic                  in_method,
    input  logic [31:0]           in_radicand,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [31:0]           out_data
);

    import sqbn_pkg::*;

    localparam int DW = 32 + FRAC_BITS;
    localparam logic [31:0] ONE = 32'(1) << FRAC_BITS;

    logic          method_reg;
    logic [DW-1:0] target_reg;
    logic [DW-1:0] p_reg;
    logic [DW-1:0] q_reg;
    logic [31:0]   mid_reg;
    logic [63:0]   prod_reg;
    logic [24:0]   root_out_reg;
    logic          conv_out_reg;
    logic          out_valid_reg;

    logic [DW-1:0] diff;
    logic          stop;
    logic [DW:0]   sum_pq;
    logic [DW:0]   sum_pn;
    logic [DW-1:0] result;
    logic [24:0]   root_sat;
    logic [31:0]   hi_init;
    logic [DW-1:0] quot;
    logic          div_done;

    sqbn_div #(
        .DW(DW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (target_reg),
        .divisor  (q_reg),
        .quot     (quot),
        .done     (div_done)
    );

    always_comb
    begin
        // p holds lo or prev, q holds hi or cur
        diff     = (q_reg >= p_reg) ? (q_reg - p_reg) : (p_reg - q_reg);
        stop     = (diff <= DW'(tolerance));
        sum_pq   = {1'b0, p_reg} + {1'b0, q_reg};
        sum_pn   = {1'b0, p_reg} + {1'b0, quot};
        result   = method_reg ? q_reg : sum_pq[DW:1];
        root_sat = (|result[DW-1:25]) ? '1 : result[24:0];
        hi_init  = (in_radicand > ONE) ? in_radicand : ONE;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            method_reg <= in_method;
            target_reg <= DW'(in_radicand) << FRAC_BITS;
            p_reg      <= '0;
            q_reg      <= in_method ? DW'(in_radicand) : DW'(hi_init);
        end
        if (cmd.mid_load)
            mid_reg <= sum_pq[32:1];
        if (cmd.mul)
            prod_reg <= 64'(mid_reg) * 64'(mid_reg);
        if (cmd.bis_upd)
        begin
            if (prod_reg > 64'(target_reg))
                q_reg <= DW'(mid_reg);
            else
                p_reg <= DW'(mid_reg);
        end
        if (cmd.new_shift)
            p_reg <= q_reg;
        if (cmd.new_upd)
            q_reg <= sum_pn[DW:1];
        if (cmd.out_load)
        begin
            root_out_reg <= root_sat;
            conv_out_reg <= stop;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign status.stop     = stop;
    assign status.newton   = method_reg;
    assign status.q_zero   = (q_reg == '0);
    assign status.div_done = div_done;
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = {6'b0, conv_out_reg, root_out_reg};

    a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result word loaded over one not yet taken");

    a_bis_upd_method: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.bis_upd |-> !method_reg)
        else $error("bisection update while newton selected");

endmodule

// File: rtl/sqbn_ctrl.sv
module sqbn_ctrl #(
    parameter int MAX_STEPS = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  sqbn_pkg::sqbn_status_t status,
    output sqbn_pkg::sqbn_cmd_t    cmd
);

    import sqbn_pkg::*;

    localparam int NW = $clog2(MAX_STEPS + 1);
    localparam logic [NW-1:0] N_MAX = NW'(MAX_STEPS);

    sqbn_state_t   state_reg, state_next;
    logic [NW-1:0] n_reg, n_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            n_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    n_next     = '0;
                    state_next = ST_TEST;
                end
            end
            ST_TEST:
            begin
                if (status.stop || (n_reg == N_MAX))
                    state_next = ST_FIN;
                else
                begin
                    n_next = n_reg + 1'b1;
                    if (status.newton)
                    begin
                        cmd.new_shift = 1'b1;
                        // a zero estimate stays zero, no divide needed
                        if (!status.q_zero)
                        begin
                            cmd.div_start = 1'b1;
                            state_next    = ST_NEW_DIV;
                        end
                    end
                    else
                    begin
                        cmd.mid_load = 1'b1;
                        state_next   = ST_BIS_MUL;
                    end
                end
            end
            ST_BIS_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_BIS_UPD;
            end
            ST_BIS_UPD:
            begin
                cmd.bis_upd = 1'b1;
                state_next  = ST_TEST;
            end
            ST_NEW_DIV:
            begin
                if (status.div_done)
                begin
                    cmd.new_upd = 1'b1;
                    state_next  = ST_TEST;
                end
            end
            ST_FIN:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_step_cap: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= N_MAX)
        else $error("step count beyond cap");

    a_div_newton: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_NEW_DIV) |-> status.newton)
        else $error("divide wait outside newton");

    a_load_test: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == ST_TEST) && (n_reg == '0))
        else $error("new word did not start at step zero");

endmodule

// File: rtl/square_root_bisection_newton_top.sv
// channel   direction  content
// s_axis    in         tuser: cmd, tdata: radicand
// m_axis    out        tdata: root, converged
// apb       in/out     tolerance register at byte address 0
//
// bisection: each step is midpoint, 32x32 square, compare
// newton: each step with a nonzero estimate waits on the 1 bit per cycle divider
// an item takes up to MAX_STEPS steps
// reset returns the controller to idle and tolerance to 66
// a new word is taken only in idle; a finished result waits in the
// output register, and the controller stalls before it if still full
module square_root_bisection_newton_top #(
    parameter int MAX_STEPS = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [31:0]                     s_axis_tdata,  // [31:0] radicand
    input  logic                            s_axis_tuser,  // [0] cmd
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [31:0]                     m_axis_tdata,  // [24:0] root, [25] converged
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sqbn_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    import sqbn_pkg::*;

    logic [15:0]  tolerance_reg;
    logic         reg_sel;
    sqbn_cmd_t    cmd;
    sqbn_status_t status;

    assign reg_sel = (paddr[2] == REG_TOLERANCE);
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? {16'b0, tolerance_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tolerance_reg <= TOLERANCE_RESET;
        else if (psel && penable && pwrite && pready && reg_sel)
            tolerance_reg <= pwdata[15:0];
    end

    sqbn_ctrl #(
        .MAX_STEPS(MAX_STEPS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sqbn_dp #(
        .FRAC_BITS(FRAC_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .tolerance   (tolerance_reg),
        .in_method   (s_axis_tuser),
        .in_radicand (s_axis_tdata),
        .out_ready   (m_axis_tready),
        .out_valid   (m_axis_tvalid),
        .out_data    (m_axis_tdata)
    );

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps

module tb;
    import sqbn_pkg::*;

    localparam int MAX_STEPS = 64;
    localparam int FRAC_BITS = 16;
    localparam logic CMD_BISECT = 1'b0;
    localparam logic CMD_NEWTON = 1'b1;
    localparam logic [APB_ADDR_W-1:0] TOL_ADDR = {REG_TOLERANCE, 2'b00};
    localparam logic [24:0] ROOT_SAT = '1;
    localparam longint CYCLE_LIMIT = 20_000_000;
    localparam int PARK_CYCLES = 3000;

    typedef struct packed {
        logic        cmd;
        logic [31:0] radicand;
    } sqrt_req_t;

    typedef struct packed {
        logic [24:0] root;
        logic        converged;
    } sqrt_res_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // [31:0] radicand
    logic        s_axis_tuser = 1'b0; // [0] cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // [24:0] root, [25] converged
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    sqrt_req_t   pending_reqs[$];
    sqrt_res_t   expected_roots[$];
    logic [15:0] tol_now = TOLERANCE_RESET;
    logic        gaps_on = 1'b1;
    logic        park_req = 1'b0;
    bit          parked = 1'b0;
    int          park_left = 0;
    int          send_hold = 0;
    int          recv_stall = 0;
    int          errors = 0;
    int          n_bisect = 0;
    int          n_newton = 0;
    int          n_checked = 0;
    int          n_queued = 0;
    int          n_capped = 0;
    int          n_settings = 0;
    longint      cycles = 0;

    square_root_bisection_newton_top #(
        .MAX_STEPS(MAX_STEPS),
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #5 clk = ~clk;

    function automatic logic [63:0] dist64(logic [63:0] p, logic [63:0] q);
        return (p >= q) ? (p - q) : (q - p);
    endfunction

    // fixed-point square root, same truncation as the hardware
    function automatic sqrt_res_t fixed_sqrt(sqrt_req_t req, logic [15:0] tol);
        logic [63:0] one;
        logic [63:0] target;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] prev;
        logic [63:0] cur;
        logic [63:0] est;
        logic        ok;
        int          n;
        sqrt_res_t   res;
        one = 64'd1 << FRAC_BITS;
        target = {32'd0, req.radicand} << FRAC_BITS;
        if (req.cmd == CMD_BISECT)
        begin
            lo = '0;
            hi = ({32'd0, req.radicand} > one) ? {32'd0, req.radicand} : one;
            for (n = 0; n < MAX_STEPS && (hi - lo) > tol; n++)
            begin
                mid = (lo + hi) >> 1;
                if (mid * mid > target)
                    hi = mid;
                else
                    lo = mid;
            end
            ok = ((hi - lo) <= tol);
            est = (lo + hi) >> 1;
        end
        else
        begin
            prev = '0;
            cur = {32'd0, req.radicand};
            for (n = 0; n < MAX_STEPS && dist64(cur, prev) > tol; n++)
            begin
                prev = cur;
                if (prev == 0)
                    cur = '0;
                else
                    cur = (prev + target / prev) >> 1;
            end
            ok = (dist64(cur, prev) <= tol);
            est = cur;
        end
        res.root = (est > {39'd0, ROOT_SAT}) ? ROOT_SAT : est[24:0];
        res.converged = ok;
        return res;
    endfunction

    // sender: one word per handshake, random gap after each while gaps_on is set
    always @(posedge clk)
    begin
        sqrt_req_t nxt;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_roots.push_back(fixed_sqrt({s_axis_tuser, s_axis_tdata}, tol_now));
                if (s_axis_tuser == CMD_NEWTON)
                    n_newton++;
                else
                    n_bisect++;
                send_hold = gaps_on ? $urandom_range(0, 14) : 0;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_hold > 0)
                begin
                    send_hold--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    nxt = pending_reqs.pop_front();
                    s_axis_tdata <= nxt.radicand;
                    s_axis_tuser <= nxt.cmd;
                    s_axis_tvalid <= 1'b1;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: checks each word against the oldest prediction
    always @(posedge clk)
    begin
        sqrt_res_t got;
        sqrt_res_t want;
        if (rst_n)
        begin
            if (park_req && !parked)
            begin
                parked = 1'b1;
                park_left = PARK_CYCLES;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.root = m_axis_tdata[24:0];
                got.converged = m_axis_tdata[25];
                if (expected_roots.size() == 0)
                begin
                    $error("tb: unexpected result root=%0h converged=%0b",
                           got.root, got.converged);
                    errors++;
                end
                else
                begin
                    want = expected_roots.pop_front();
                    n_checked++;
                    if (!want.converged)
                        n_capped++;
                    if (got.root !== want.root)
                    begin
                        $error("tb: root expected %0h got %0h", want.root, got.root);
                        errors++;
                    end
                    if (got.converged !== want.converged)
                    begin
                        $error("tb: converged expected %0b got %0b",
                               want.converged, got.converged);
                        errors++;
                    end
                end
                recv_stall = gaps_on ? $urandom_range(0, 14) : 0;
            end
            if (park_left > 0)
            begin
                park_left--;
                m_axis_tready <= 1'b0;
            end
            else if (recv_stall > 0)
            begin
                recv_stall--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: timeout after %0d cycles", cycles);
            $display("tb: errors");
            $finish;
        end
    end

    task automatic read_tolerance(input logic [15:0] want);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= TOL_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[15:0] !== want)
        begin
            $error("tb: tolerance readback expected %0d got %0d", want, prdata[15:0]);
            errors++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_tolerance(input logic [15:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= TOL_ADDR;
        pwdata <= {16'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        tol_now = value;
        n_settings++;
        read_tolerance(value);
    endtask

    // block is idle once every queued word has had its root taken
    task automatic drain();
        while (n_checked < n_queued)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic push_both(input logic [31:0] r);
        pending_reqs.push_back({CMD_BISECT, r});
        pending_reqs.push_back({CMD_NEWTON, r});
        n_queued += 2;
    endtask

    task automatic random_phase(input logic [15:0] tol, input int count, input logic idle);
        sqrt_req_t req;
        set_tolerance(tol);
        gaps_on <= idle;
        for (int i = 0; i < count; i++)
        begin
            req.cmd = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 4))
                0: req.radicand = $urandom_range(0, 255);
                1: req.radicand = $urandom_range(0, 32'h0003_FFFF);
                2: req.radicand = $urandom() >> $urandom_range(0, 31);
                default: req.radicand = $urandom();
            endcase
            pending_reqs.push_back(req);
            n_queued++;
        end
        drain();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        read_tolerance(TOLERANCE_RESET);

        // reset tolerance: zero, tiny radicands under newton, one, top of range
        push_both(32'h0000_0000);
        push_both(32'h0000_0001);
        push_both(32'h0000_0042);
        push_both(32'h0000_0043);
        push_both(32'h0000_4000);
        push_both(32'h0001_0000);
        push_both(32'h0002_0000);
        push_both(32'h5555_5555);
        push_both(32'hAAAA_AAAA);
        push_both(32'h7FFF_FFFF);
        push_both(32'h8000_0000);
        push_both(32'hFFFF_FFFF);
        drain();

        // zero tolerance: bisection never stops early and hits the cap, newton stops once its estimate repeats
        set_tolerance(16'd0);
        push_both(32'h0000_0000);
        push_both(32'h0000_0003);
        push_both(32'h0002_0000);
        push_both(32'hFFFF_FFFF);
        drain();

        random_phase(16'd1, 270, 1'b1);
        // long receiver hold-off while the sender keeps offering
        park_req <= 1'b1;
        random_phase(16'hFFFF, 270, 1'b0);
        random_phase(TOLERANCE_RESET, 270, 1'b1);
        random_phase(16'($urandom_range(1, 300)), 270, 1'b0);
        random_phase(16'($urandom_range(1, 16'hFFFF)), 270, 1'b1);
        random_phase(16'($urandom_range(1, 16'hFFFF)), 270, 1'b1);
        random_phase(16'($urandom_range(2, 16)), 270, 1'b1);

        repeat (50) @(posedge clk);
        $display("tb: %0d roots checked, %0d bisection and %0d newton, %0d hit the step cap",
                 n_checked, n_bisect, n_newton, n_capped);
        $display("tb: %0d tolerance settings including 0, 1 and 65535", n_settings);
        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

// File: filelist.f
rtl/sqbn_pkg.sv
rtl/sqbn_div.sv
rtl/sqbn_dp.sv
rtl/sqbn_ctrl.sv
rtl/square_root_bisection_newton_top.sv
sim/tb.sv
